// ===== rtl/core/vmt_pkg.sv =====
// Shared types and widths for the vertex matrix transform.
`timescale 1ns / 1ps
`default_nettype none

package vmt_pkg;

	localparam int unsigned COMP_W    = 32;
	localparam int unsigned PROD_W    = 2 * COMP_W;
	localparam int unsigned PAIR_W    = PROD_W + 1;
	localparam int unsigned SUM_W     = PROD_W + 2;
	localparam int unsigned DIM       = 4;
	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned REG_W     = 2 * COMP_W;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

	localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
	localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t [DIM-1:0][DIM-1:0] matrix_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] in_x;
		logic signed [COMP_W-1:0] in_y;
		logic signed [COMP_W-1:0] in_z;
		logic signed [COMP_W-1:0] in_w;
	} vertex_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_x;
		logic signed [COMP_W-1:0] out_y;
		logic signed [COMP_W-1:0] out_z;
		logic signed [COMP_W-1:0] out_w;
		logic                     overflow;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/vertex_matrix_transform.sv =====
// Top level: row vertex times 4x4 Q fixed-point matrix, saturated.
//
//   channel  handshake              payload     notes
//   vertex   vtx_valid/vtx_ready    vtx         vertex_t, one request per vertex
//   result   res_valid/res_ready    res         result_t, one per vertex
//   config   cfg_we                 cfg_index   cfg_data, 64-bit row pair write
//
// Pipeline stages: multiply, two adder levels, shift/saturate.
// Throughput one vertex per cycle while res_ready does not stall the result, set by the 16 parallel 32x32 multipliers.
// Reset clears all stage valid bits and loads the identity matrix.
// A stalled result holds its stage; upstream stages keep filling bubbles.
`timescale 1ns / 1ps
`default_nettype none

module vertex_matrix_transform
	import vmt_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 vtx_valid,
	output logic                      vtx_ready,
	input  wire vertex_t              vtx,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output result_t                   res,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data
);

	matrix_t matrix;

	vmt_cfg_regs #(
		.FRAC_BITS(FRAC_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.matrix   (matrix)
	);

	vmt_mac_pipe #(
		.FRAC_BITS(FRAC_BITS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.matrix   (matrix),
		.vtx_valid(vtx_valid),
		.vtx_ready(vtx_ready),
		.vtx      (vtx),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

`default_nettype wire

// ===== rtl/core/vmt_cfg_regs.sv =====
// Matrix coefficient registers with identity reset.
`timescale 1ns / 1ps
`default_nettype none

module vmt_cfg_regs
	import vmt_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	output matrix_t                   matrix
);

	localparam logic [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_BITS;

	logic [REG_W-1:0] reg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// diagonal: low half of registers 0 and 5, high half of 2 and 7
			for (int k = 0; k < NUM_REGS; k++) begin
				if (k == 0 || k == 5) begin
					reg_q[k] <= {{COMP_W{1'b0}}, ONE};
				end else if (k == 2 || k == 7) begin
					reg_q[k] <= {ONE, {COMP_W{1'b0}}};
				end else begin
					reg_q[k] <= '0;
				end
			end
		end else if (cfg_we) begin
			reg_q[cfg_index] <= cfg_data;
		end
	end

	// row r, column c lives in register 2r + c/2, half c%2
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				matrix[r][c] = reg_q[REG_IDX_W'(2 * r + c / 2)][(c % 2) * COMP_W +: COMP_W];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vmt_mac_pipe.sv =====
// Four-stage multiply, add-tree and saturate pipeline.
`timescale 1ns / 1ps
`default_nettype none

module vmt_mac_pipe
	import vmt_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire matrix_t matrix,
	input  wire logic    vtx_valid,
	output logic         vtx_ready,
	input  wire vertex_t vtx,
	output logic         res_valid,
	input  wire logic    res_ready,
	output result_t      res
);

	localparam int unsigned HI_W = SUM_W - COMP_W + 1;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;

	logic signed [PROD_W-1:0] prod_s1 [DIM][DIM];
	logic signed [PAIR_W-1:0] pair_s2 [DIM][2];
	logic signed [SUM_W-1:0]  sum_s3  [DIM];
	comp_t                    comp_s4 [DIM];
	logic                     ovf_s4;

	comp_t                    vin [DIM];
	logic signed [PROD_W-1:0] prod_d [DIM][DIM];
	logic signed [SUM_W-1:0]  shifted [DIM];
	comp_t                    comp_d [DIM];
	logic [DIM-1:0]           clip_d;

	assign adv4      = !valid_s4 || res_ready;
	assign adv3      = !valid_s3 || adv4;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign vtx_ready = adv1;

	assign vin[0] = vtx.in_x;
	assign vin[1] = vtx.in_y;
	assign vin[2] = vtx.in_z;
	assign vin[3] = vtx.in_w;

	// prod_d[i][j] = v[i] * M[i][j]
	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				prod_d[i][j] = vin[i] * $signed(matrix[i][j]);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			shifted[j] = sum_s3[j] >>> FRAC_BITS;
			if (shifted[j][SUM_W-1:COMP_W-1] != {HI_W{shifted[j][SUM_W-1]}}) begin
				clip_d[j] = 1'b1;
				comp_d[j] = shifted[j][SUM_W-1] ? COMP_MIN : COMP_MAX;
			end else begin
				clip_d[j] = 1'b0;
				comp_d[j] = shifted[j][COMP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= vtx_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && vtx_valid) begin
			prod_s1 <= prod_d;
		end
		if (adv2 && valid_s1) begin
			for (int j = 0; j < DIM; j++) begin
				pair_s2[j][0] <= prod_s1[0][j] + prod_s1[1][j];
				pair_s2[j][1] <= prod_s1[2][j] + prod_s1[3][j];
			end
		end
		if (adv3 && valid_s2) begin
			for (int j = 0; j < DIM; j++) begin
				sum_s3[j] <= pair_s2[j][0] + pair_s2[j][1];
			end
		end
		if (adv4 && valid_s3) begin
			comp_s4 <= comp_d;
			ovf_s4  <= |clip_d;
		end
	end

	assign res_valid    = valid_s4;
	assign res.out_x    = comp_s4[0];
	assign res.out_y    = comp_s4[1];
	assign res.out_z    = comp_s4[2];
	assign res.out_w    = comp_s4[3];
	assign res.overflow = ovf_s4;

`ifndef NO_ASSERTIONS
	a_ovf_clips: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && ovf_s4 |->
			comp_s4[0] == COMP_MAX || comp_s4[0] == COMP_MIN ||
			comp_s4[1] == COMP_MAX || comp_s4[1] == COMP_MIN ||
			comp_s4[2] == COMP_MAX || comp_s4[2] == COMP_MIN ||
			comp_s4[3] == COMP_MAX || comp_s4[3] == COMP_MIN)
		else $error("overflow set with no clipped component");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s4) |-> $past(valid_s3))
		else $error("result appeared without a stage-3 request");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv2 |=> valid_s1 && $stable(prod_s1[0][0]) && $stable(prod_s1[3][3]))
		else $error("stage 1 request changed while stalled");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vtx_ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && !res_ready)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for vertex_matrix_transform: vertex stream against a Q16.16 matrix predictor.
`timescale 1ns / 1ps

module tb_top;
	import vmt_pkg::*;

	localparam int    FRAC        = 16;
	localparam comp_t ONE         = comp_t'(1 << FRAC);
	localparam comp_t HALF        = comp_t'(1 << (FRAC - 1));
	localparam int    PHASE_ITEMS = 156;
	localparam int    NUM_PHASES  = 8;
	localparam int    MAX_REPORTS = 10;
	localparam int    TIMEOUT_NS  = 3000000;

	typedef enum logic [REG_IDX_W-1:0] {
		ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
		ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
	} reg_index_e;

	typedef enum int {
		MAT_IDENTITY, MAT_HALF, MAT_MAX, MAT_MIN,
		MAT_FULL, MAT_SMALL, MAT_MIXED, MAT_ZERO
	} matrix_kind_e;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 vtx_valid = 1'b0;
	logic                 vtx_ready;
	vertex_t              vtx       = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	result_t              res;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data  = '0;

	comp_t   coef_mat [DIM][DIM];
	vertex_t vertex_q [$];
	result_t transformed_q [$];
	result_t predicted;
	int      send_gap   = 0;
	int      recv_stall = 0;
	int      mismatches = 0;
	bit      send_burst = 1'b0;
	bit      recv_burst = 1'b0;

	matrix_kind_e phase_kinds [NUM_PHASES] = '{
		MAT_FULL, MAT_SMALL, MAT_MIXED, MAT_MAX, MAT_MIN, MAT_ZERO, MAT_SMALL, MAT_IDENTITY
	};

	vertex_matrix_transform #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.vtx_valid(vtx_valid),
		.vtx_ready(vtx_ready),
		.vtx      (vtx),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic comp_t pick_small(int span);
		int s;
		s = $urandom_range(0, 2 * span);
		return comp_t'(s - span);
	endfunction

	function automatic comp_t pick_extreme();
		case ($urandom_range(0, 7))
			0: return COMP_MAX;
			1: return COMP_MIN;
			2: return '0;
			3: return ONE;
			4: return -ONE;
			5: return -32'sd1;
			6: return 32'sd1;
			default: return comp_t'($urandom);
		endcase
	endfunction

	function automatic comp_t pick_comp();
		case ($urandom_range(0, 4))
			0, 1: return comp_t'($urandom);
			2, 3: return pick_small(1 << 21);
			default: return pick_extreme();
		endcase
	endfunction

	// Exact 66-bit sum of four products, floor shift, saturate.
	function automatic result_t transform_vertex(vertex_t v);
		comp_t                      comps [DIM];
		comp_t                      outs [DIM];
		logic signed [PROD_W-1:0]   prod;
		logic signed [SUM_W-1:0]    acc;
		logic                       clipped;
		result_t                    r;
		comps[0] = v.in_x;
		comps[1] = v.in_y;
		comps[2] = v.in_z;
		comps[3] = v.in_w;
		clipped = 1'b0;
		for (int j = 0; j < DIM; j++) begin
			acc = '0;
			for (int i = 0; i < DIM; i++) begin
				prod = comps[i] * coef_mat[i][j];
				acc = acc + prod;
			end
			acc = acc >>> FRAC;
			if (acc > COMP_MAX) begin
				outs[j] = COMP_MAX;
				clipped = 1'b1;
			end else if (acc < COMP_MIN) begin
				outs[j] = COMP_MIN;
				clipped = 1'b1;
			end else begin
				outs[j] = acc[COMP_W-1:0];
			end
		end
		r.out_x = outs[0];
		r.out_y = outs[1];
		r.out_z = outs[2];
		r.out_w = outs[3];
		r.overflow = clipped;
		return r;
	endfunction

	task automatic write_reg(input reg_index_e idx, input logic [REG_W-1:0] data);
		int row;
		int col;
		row = int'(idx) / 2;
		col = (int'(idx) % 2) * 2;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		coef_mat[row][col]     = data[COMP_W-1:0];
		coef_mat[row][col + 1] = data[REG_W-1:COMP_W];
	endtask

	task automatic load_matrix(input matrix_kind_e kind);
		comp_t c [DIM][DIM];
		for (int r = 0; r < DIM; r++) begin
			for (int k = 0; k < DIM; k++) begin
				case (kind)
					MAT_IDENTITY: c[r][k] = (r == k) ? ONE : '0;
					MAT_HALF:     c[r][k] = HALF;
					MAT_MAX:      c[r][k] = COMP_MAX;
					MAT_MIN:      c[r][k] = COMP_MIN;
					MAT_FULL:     c[r][k] = comp_t'($urandom);
					MAT_SMALL:    c[r][k] = pick_small(1 << 17);
					MAT_MIXED:    c[r][k] = pick_extreme();
					default:      c[r][k] = '0;
				endcase
			end
		end
		for (int r = 0; r < DIM; r++) begin
			for (int h = 0; h < 2; h++) begin
				write_reg(reg_index_e'(2 * r + h), {c[r][2 * h + 1], c[r][2 * h]});
			end
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_vertex(input comp_t x, input comp_t y, input comp_t z, input comp_t w);
		vertex_t v;
		v.in_x = x;
		v.in_y = y;
		v.in_z = z;
		v.in_w = w;
		vertex_q.push_back(v);
	endtask

	task automatic push_random(input int count);
		for (int n = 0; n < count; n++) begin
			push_vertex(pick_comp(), pick_comp(), pick_comp(), pick_comp());
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		while (vertex_q.size() != 0 || vtx_valid || transformed_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic flag_mismatch(input string why, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t %s: expected x=%h y=%h z=%h w=%h ovf=%b, got x=%h y=%h z=%h w=%h ovf=%b",
				$time, why, want.out_x, want.out_y, want.out_z, want.out_w, want.overflow,
				got.out_x, got.out_y, got.out_z, got.out_w, got.overflow);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (vtx_valid && vtx_ready) begin
				transformed_q.push_back(transform_vertex(vtx));
				send_gap = send_burst ? 0 : $urandom_range(0, 5);
			end
			if (vtx_valid && !vtx_ready) begin
				// hold the pending request
			end else if (send_gap > 0) begin
				send_gap--;
				vtx_valid <= 1'b0;
			end else if (vertex_q.size() != 0) begin
				vtx       <= vertex_q.pop_front();
				vtx_valid <= 1'b1;
			end else begin
				vtx_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (transformed_q.size() == 0) begin
					flag_mismatch("unexpected result", '0, res);
				end else begin
					predicted = transformed_q.pop_front();
					if (res.out_x !== predicted.out_x || res.out_y !== predicted.out_y ||
						res.out_z !== predicted.out_z || res.out_w !== predicted.out_w ||
						res.overflow !== predicted.overflow) begin
						flag_mismatch("result mismatch", predicted, res);
					end
				end
				recv_stall = recv_burst ? 0 : $urandom_range(0, 5);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("** vertex_matrix_transform: FAILED **");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity: values pass through unchanged
		load_matrix(MAT_IDENTITY);
		push_vertex('0, '0, '0, '0);
		push_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
		push_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
		push_vertex(-32'sd1, 32'sd1, -ONE, ONE);
		push_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8765_4321);
		wait_drain();

		// half coefficients: floor rounding of negative fractions
		load_matrix(MAT_HALF);
		push_vertex(-32'sd1, '0, '0, '0);
		push_vertex(32'sd1, '0, '0, '0);
		push_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
		push_vertex(32'sd3, '0, '0, -32'sd1);
		push_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
		wait_drain();

		// largest positive coefficients: saturation both ways
		load_matrix(MAT_MAX);
		push_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
		push_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
		push_vertex(COMP_MAX, COMP_MIN, '0, '0);
		push_vertex('0, '0, '0, '0);
		push_vertex(32'sd1, '0, '0, '0);
		wait_drain();

		// most negative coefficients
		load_matrix(MAT_MIN);
		push_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
		push_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
		push_vertex(-32'sd1, '0, '0, '0);
		push_vertex('0, '0, '0, 32'sd1);
		wait_drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			load_matrix(phase_kinds[p]);
			if (p == 2) begin
				// sender holds off until the pipe is empty
				push_random(PHASE_ITEMS / 2);
				wait_drain();
				push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				push_random(PHASE_ITEMS);
			end
			wait_drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("** vertex_matrix_transform: PASSED **");
		end else begin
			$display("** vertex_matrix_transform: FAILED **");
		end
		$finish;
	end

endmodule
